// ===== rtl/vn2d_pkg.sv =====
// Shared types and constants for the 2-D vector normalizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vn2d_pkg;

  localparam int COMP_W     = 16;
  localparam int LEN_W      = 24;
  localparam int SQ_W       = 32;
  localparam int SQ_STAGES  = 12;
  localparam int DIV_STAGES = 8;
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 24'd1;
  localparam logic [COMP_W-1:0] UNIT_SAT     = 16'd32767;

  // Sideband that rides along the square-root pipeline
  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic                     mode;
  } sq_side_t;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             zero;
    logic             neg_a;
    logic             neg_b;
  } div_side_t;

endpackage

// ===== rtl/vn2d_sqrt.sv =====
// Pipelined bit-by-bit integer square root of a 32-bit sum scaled by 2^16.
// Two result bits per stage over twelve stages. Depends on vn2d_pkg.
`timescale 1ns / 1ps

module vn2d_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [vn2d_pkg::SQ_W-1:0] in_val,
  input  vn2d_pkg::sq_side_t       in_side,
  output logic                     out_vld,
  output logic [vn2d_pkg::LEN_W-1:0] out_root,
  output vn2d_pkg::sq_side_t       out_side
);
  import vn2d_pkg::*;

  logic [SQ_STAGES-1:0] vld_r;
  logic [47:0]          v_r    [SQ_STAGES];
  logic [LEN_W-1:0]     res_r  [SQ_STAGES];
  logic [26:0]          rem_r  [SQ_STAGES];
  sq_side_t             side_r [SQ_STAGES];

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
    logic [47:0]      v_i;
    logic [LEN_W-1:0] res_i;
    logic [26:0]      rem_i;
    logic             vld_i;
    sq_side_t         side_i;
    logic [LEN_W-1:0] res_nxt;
    logic [26:0]      rem_nxt;

    // Pick stage inputs
    if (i == 0) begin : g_first
      assign v_i    = {in_val, 16'h0000};
      assign res_i  = '0;
      assign rem_i  = '0;
      assign vld_i  = in_vld;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[i-1];
      assign res_i  = res_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign vld_i  = vld_r[i-1];
      assign side_i = side_r[i-1];
    end

    // Resolve two root bits
    always_comb begin
      logic [26:0]      r;
      logic [LEN_W-1:0] q;
      logic [26:0]      t;
      r = rem_i;
      q = res_i;
      for (int s = 0; s < 2; s++) begin
        r = {r[24:0], v_i[47-2*s -: 2]};
        t = {1'b0, q, 2'b01};
        if (r >= t) begin
          r = r - t;
          q = {q[LEN_W-2:0], 1'b1};
        end else begin
          q = {q[LEN_W-2:0], 1'b0};
        end
      end
      rem_nxt = r;
      res_nxt = q;
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[i]    <= {v_i[43:0], 4'h0};
        res_r[i]  <= res_nxt;
        rem_r[i]  <= rem_nxt;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = res_r[SQ_STAGES-1];
  assign out_side = side_r[SQ_STAGES-1];

endmodule

// ===== rtl/vn2d_div.sv =====
// Pipelined two-lane restoring divider: mag * 2^23 / len, 16-bit quotients.
// Two quotient bits per stage over eight stages. Depends on vn2d_pkg.
`timescale 1ns / 1ps

module vn2d_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [vn2d_pkg::COMP_W-1:0] in_mag_a,
  input  logic [vn2d_pkg::COMP_W-1:0] in_mag_b,
  input  vn2d_pkg::div_side_t        in_side,
  output logic                       out_vld,
  output logic [vn2d_pkg::COMP_W-1:0] out_q_a,
  output logic [vn2d_pkg::COMP_W-1:0] out_q_b,
  output vn2d_pkg::div_side_t        out_side
);
  import vn2d_pkg::*;

  logic [DIV_STAGES-1:0] vld_r;
  logic [38:0]           ra_r   [DIV_STAGES];
  logic [38:0]           rb_r   [DIV_STAGES];
  logic [COMP_W-1:0]     qa_r   [DIV_STAGES];
  logic [COMP_W-1:0]     qb_r   [DIV_STAGES];
  div_side_t             side_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [38:0]       ra_i, rb_i, ra_nxt, rb_nxt;
    logic [COMP_W-1:0] qa_i, qb_i, qa_nxt, qb_nxt;
    logic              vld_i;
    div_side_t         side_i;

    // Pick stage inputs
    if (j == 0) begin : g_first
      assign ra_i   = {in_mag_a, 23'd0};
      assign rb_i   = {in_mag_b, 23'd0};
      assign qa_i   = '0;
      assign qb_i   = '0;
      assign vld_i  = in_vld;
      assign side_i = in_side;
    end else begin : g_next
      assign ra_i   = ra_r[j-1];
      assign rb_i   = rb_r[j-1];
      assign qa_i   = qa_r[j-1];
      assign qb_i   = qb_r[j-1];
      assign vld_i  = vld_r[j-1];
      assign side_i = side_r[j-1];
    end

    // Resolve two quotient bits in each lane
    always_comb begin
      logic [39:0] d;
      logic [38:0] ra, rb;
      logic [COMP_W-1:0] qa, qb;
      ra = ra_i;
      rb = rb_i;
      qa = qa_i;
      qb = qb_i;
      for (int s = 0; s < 2; s++) begin
        d = {16'd0, side_i.len} << (15 - 2*j - s);
        if ({1'b0, ra} >= d) begin
          ra = ra - d[38:0];
          qa = {qa[COMP_W-2:0], 1'b1};
        end else begin
          qa = {qa[COMP_W-2:0], 1'b0};
        end
        if ({1'b0, rb} >= d) begin
          rb = rb - d[38:0];
          qb = {qb[COMP_W-2:0], 1'b1};
        end else begin
          qb = {qb[COMP_W-2:0], 1'b0};
        end
      end
      ra_nxt = ra;
      rb_nxt = rb;
      qa_nxt = qa;
      qb_nxt = qb;
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra_r[j]   <= ra_nxt;
        rb_r[j]   <= rb_nxt;
        qa_r[j]   <= qa_nxt;
        qb_r[j]   <= qb_nxt;
        side_r[j] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_q_a  = qa_r[DIV_STAGES-1];
  assign out_q_b  = qb_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

endmodule

// ===== rtl/vector_normalize_2d_core.sv =====
// Throughput is one per cycle unless stalled: squaring, a 12-stage root and an 8-stage divider all pipeline.
// A stalled output freezes the whole pipeline; in_ready falls only while a result waits.
// Reset (rst_n, synchronous, active low) clears all valid bits and sets min_length to 1.
// Top level of the 2-D vector normalizer; depends on vn2d_pkg, vn2d_sqrt, vn2d_div.
`timescale 1ns / 1ps

module vector_normalize_2d_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_min_length,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_x_in,
  input  logic signed [15:0]  in_y_in,
  input  logic                in_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_unit_x,
  output logic signed [15:0]  out_unit_y,
  output logic [23:0]         out_length_q8,
  output logic                out_is_zero
);
  import vn2d_pkg::*;

  logic             en;
  logic [LEN_W-1:0] min_len_r;

  logic             s0_vld_r;
  sq_side_t         s0_side_r;
  logic             s1_vld_r;
  logic [SQ_W-1:0]  s1_xx_r, s1_yy_r;
  sq_side_t         s1_side_r;
  logic             s2_vld_r;
  logic [SQ_W-1:0]  s2_sum_r;
  sq_side_t         s2_side_r;

  logic             rt_vld;
  logic [LEN_W-1:0] rt_root;
  sq_side_t         rt_side;

  logic              s3_vld_r;
  logic [COMP_W-1:0] s3_mag_a_r, s3_mag_b_r;
  div_side_t         s3_side_r;
  logic [COMP_W-1:0] mag_x, mag_y;
  logic              y_pos;

  logic              dv_vld;
  logic [COMP_W-1:0] dv_qa, dv_qb;
  div_side_t         dv_side;
  logic [COMP_W-1:0] sat_a, sat_b;

  logic              out_vld_r;
  logic [COMP_W-1:0] ux_r, uy_r;
  logic [LEN_W-1:0]  len_r;
  logic              zero_r;

  // Global advance: move unless a finished result is held
  assign en        = !out_vld_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_valid) begin
      min_len_r <= cfg_min_length;
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= rt_vld;
    end
  end

  // Capture request, square components, sum
  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= '{x: in_x_in, y: in_y_in, mode: in_mode};
      s1_xx_r   <= SQ_W'($signed(s0_side_r.x) * $signed(s0_side_r.x));
      s1_yy_r   <= SQ_W'($signed(s0_side_r.y) * $signed(s0_side_r.y));
      s1_side_r <= s0_side_r;
      s2_sum_r  <= s1_xx_r + s1_yy_r;
      s2_side_r <= s1_side_r;
    end
  end

  vn2d_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_val   (s2_sum_r),
    .in_side  (s2_side_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  // Magnitudes and signs of the selected components
  assign mag_x = rt_side.x[15] ? COMP_W'(-rt_side.x) : rt_side.x;
  assign mag_y = rt_side.y[15] ? COMP_W'(-rt_side.y) : rt_side.y;
  assign y_pos = !rt_side.y[15] && (rt_side.y != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.len  <= rt_root;
      s3_side_r.zero <= (rt_root == '0) || (rt_root < min_len_r);
      if (rt_side.mode) begin
        s3_mag_a_r      <= mag_y;
        s3_mag_b_r      <= mag_x;
        s3_side_r.neg_a <= y_pos;
        s3_side_r.neg_b <= rt_side.x[15];
      end else begin
        s3_mag_a_r      <= mag_x;
        s3_mag_b_r      <= mag_y;
        s3_side_r.neg_a <= rt_side.x[15];
        s3_side_r.neg_b <= rt_side.y[15];
      end
    end
  end

  vn2d_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .in_mag_a (s3_mag_a_r),
    .in_mag_b (s3_mag_b_r),
    .in_side  (s3_side_r),
    .out_vld  (dv_vld),
    .out_q_a  (dv_qa),
    .out_q_b  (dv_qb),
    .out_side (dv_side)
  );

  // Saturate quotients
  assign sat_a = (dv_qa > UNIT_SAT) ? UNIT_SAT : dv_qa;
  assign sat_b = (dv_qb > UNIT_SAT) ? UNIT_SAT : dv_qb;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= dv_side.zero;
      if (dv_side.zero) begin
        ux_r  <= '0;
        uy_r  <= '0;
        len_r <= '0;
      end else begin
        ux_r  <= dv_side.neg_a ? COMP_W'(-sat_a) : sat_a;
        uy_r  <= dv_side.neg_b ? COMP_W'(-sat_b) : sat_b;
        len_r <= dv_side.len;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_unit_x    = ux_r;
  assign out_unit_y    = uy_r;
  assign out_length_q8 = len_r;
  assign out_is_zero   = zero_r;

`ifndef NO_ASSERTIONS
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && zero_r) |-> (ux_r == '0 && uy_r == '0 && len_r == '0))
    else $error("zero result carries nonzero fields");

  a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !zero_r) |-> (len_r != '0))
    else $error("nonzero result with zero length");

  a_no_min_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (ux_r != 16'h8000 && uy_r != 16'h8000))
    else $error("unit component escaped saturation");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(len_r) && $stable(ux_r)))
    else $error("stalled result changed");
`endif

endmodule
